>>> rtl/stl_pkg.sv
// shared types, codes and character helpers for the source text lexer
`default_nettype none
package stl_pkg;
    localparam int PosBits = 16;
    localparam int MaxRes = 6;

    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_LINEC, M_BLOCK, M_BSTAR, M_STR, M_STRESC,
        M_CHOPEN, M_CHESC, M_CHCLOSE, M_NZERO, M_NINT, M_HEX, M_FRAC,
        M_EXPS, M_EXP, M_SUFD, M_IDENT
    } t_mode;

    localparam logic [3:0] T_EOF = 4'd0, T_STR = 4'd1, T_INT = 4'd2, T_HEX = 4'd3,
        T_CHAR = 4'd4, T_FLOAT = 4'd5, T_DOUBLE = 4'd6, T_SYM = 4'd7, T_IDENT = 4'd8;
    localparam logic [1:0] K_VAL = 2'd0, K_DONE = 2'd1, K_ERR = 2'd2;
    localparam logic [2:0] E_BLOCK = 3'd0, E_STRNL = 3'd1, E_ESC = 3'd2,
        E_STREND = 3'd3, E_CHAR = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         ttype;
        logic [7:0]         val;
        logic [2:0]         err;
        logic [PosBits-1:0] line;
        logic [PosBits-1:0] col;
        logic               any_err;
    } t_res;

    typedef struct packed {
        logic [2:0]  cnt;
        t_res [MaxRes-1:0] res;
    } t_batch;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction
    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d;
    endfunction
endpackage
`default_nettype wire

>>> rtl/source_text_lexer.sv
// top level of the streaming source text lexer
// channel | dir | handshake           | payload
// in      | in  | i_valid / o_ready   | i_ch, i_end_of_source
// out     | out | o_valid / i_ready   | o_item_kind .. o_last
// each input beat is decoded combinationally into a batch of up to six results
// the batch register drains one result per cycle when not stalled; a beat with
// n results holds the input until drained, none or one pass at one per cycle
// reset returns to the idle mode at line 1, column 0; no clearing pass
// stalls on the output keep the batch and hold o_ready low until it drains
`default_nettype none
module source_text_lexer import stl_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_ch,
    input  wire logic               i_end_of_source,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_item_kind,
    output logic [3:0]              o_token_type,
    output logic [7:0]              o_value_char,
    output logic [2:0]              o_error_code,
    output logic [PosBits-1:0]      o_line,
    output logic [PosBits-1:0]      o_column,
    output logic                    o_any_error,
    output logic                    o_last
);
    t_batch batch;
    t_res   res;
    logic   free;

    stl_core u_core (
        .i_clk, .i_rst_n, .i_go(i_valid && free), .i_ch,
        .i_eos(i_end_of_source), .o_batch(batch)
    );

    stl_outq u_outq (
        .i_clk, .i_rst_n, .i_load(i_valid), .i_batch(batch), .o_free(free),
        .o_valid, .i_ready, .o_res(res), .o_last
    );

    assign o_ready      = free;
    assign o_item_kind  = res.kind;
    assign o_token_type = res.ttype;
    assign o_value_char = res.val;
    assign o_error_code = res.err;
    assign o_line       = res.line;
    assign o_column     = res.col;
    assign o_any_error  = res.any_err;
endmodule
`default_nettype wire

>>> rtl/stl_core.sv
// lexer state and step logic, run again on a byte not consumed, producing a batch of results
`default_nettype none
module stl_core import stl_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_go,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_eos,
    output t_batch          o_batch
);
    localparam logic [PosBits-1:0] PosMax = '1;

    t_mode              r_mode, n_mode;
    logic [PosBits-1:0] r_line, n_line, r_col, n_col;
    logic [3:0]         r_type, n_type;
    logic               r_err, n_err, r_eof, n_eof;
    t_batch             b;

    // step over one byte; returns consumed
    function automatic logic bstep(input logic [7:0] c, inout t_mode m,
            inout logic [PosBits-1:0] ln, inout logic [PosBits-1:0] cl,
            inout logic [3:0] ty, inout logic er, inout t_batch bt);
        logic cons;
        logic known;
        logic [7:0] v;
        cons = 1'b1;
        known = 1'b1;
        v = c;
        case (c)
            "n": v = 8'd10;
            "t": v = 8'd9;
            "b": v = 8'd8;
            8'h22, 8'h5c: v = c;
            default: known = 1'b0;
        endcase
        case (m)
            M_SLASH: begin
                if (c == "/") begin cl = bump(cl); m = M_LINEC; end
                else if (c == "*") begin cl = bump(cl); m = M_BLOCK; end
                else begin
                    ty = T_SYM; put(bt, K_VAL, ty, "/", 0, ln, cl);
                    put(bt, K_DONE, ty, 0, 0, ln, cl); m = M_IDLE; cons = 0;
                end
            end
            M_LINEC: begin
                if (c == 8'h0a) begin m = M_IDLE; cons = 0; end
                else cl = bump(cl);
            end
            M_BLOCK, M_BSTAR: begin
                if (c == 8'h0a) begin
                    if (ln != PosMax) ln = ln + 1'b1;
                    cl = '0; m = M_BLOCK;
                end else begin
                    cl = bump(cl);
                    if (m == M_BSTAR && c == "/") m = M_IDLE;
                    else m = (c == "*") ? M_BSTAR : M_BLOCK;
                end
            end
            M_STR, M_STRESC, M_CHOPEN, M_CHESC: begin
                if (c == 8'h0a) begin
                    er = 1;
                    put(bt, K_ERR, T_EOF, 0,
                        (m == M_STR || m == M_STRESC) ? E_STRNL : E_CHAR, ln, cl);
                    put(bt, K_DONE, ty, 0, 0, ln, cl); m = M_IDLE; cons = 0;
                end else begin
                    cl = bump(cl);
                    if (m == M_STR) begin
                        if (c == 8'h22) begin put(bt, K_DONE, ty, 0, 0, ln, cl); m = M_IDLE; end
                        else if (c == 8'h5c) m = M_STRESC;
                        else put(bt, K_VAL, ty, c, 0, ln, cl);
                    end else if (m == M_CHOPEN) begin
                        if (c == 8'h5c) m = M_CHESC;
                        else begin put(bt, K_VAL, ty, c, 0, ln, cl); m = M_CHCLOSE; end
                    end else begin
                        if (!known) begin er = 1; put(bt, K_ERR, T_EOF, 0, E_ESC, ln, cl); end
                        put(bt, K_VAL, ty, v, 0, ln, cl);
                        m = (m == M_STRESC) ? M_STR : M_CHCLOSE;
                    end
                end
            end
            M_CHCLOSE: begin
                if (c == 8'h27) begin
                    cl = bump(cl); put(bt, K_DONE, ty, 0, 0, ln, cl); m = M_IDLE;
                end else begin
                    er = 1; put(bt, K_ERR, T_EOF, 0, E_CHAR, ln, cl);
                    put(bt, K_DONE, ty, 0, 0, ln, cl); m = M_IDLE; cons = 0;
                end
            end
            M_NZERO, M_NINT, M_HEX, M_FRAC, M_EXPS, M_EXP: begin
                if (m == M_NZERO && (c == "x" || c == "X")) begin
                    cl = bump(cl); ty = T_HEX; put(bt, K_VAL, ty, c, 0, ln, cl); m = M_HEX;
                end else if (m == M_HEX ? is_xdigit(c) :
                        (is_digit(c) || (m == M_EXPS && (c == "+" || c == "-")))) begin
                    cl = bump(cl); put(bt, K_VAL, ty, c, 0, ln, cl);
                    if (m == M_NZERO) m = M_NINT;
                    else if (m == M_EXPS) m = M_EXP;
                end else if ((m == M_NZERO || m == M_NINT || m == M_HEX) && c == ".") begin
                    cl = bump(cl); ty = T_FLOAT; put(bt, K_VAL, ty, c, 0, ln, cl); m = M_FRAC;
                end else if ((m == M_NZERO || m == M_NINT || m == M_FRAC)
                        && (c == "e" || c == "E")) begin
                    cl = bump(cl); ty = T_FLOAT; put(bt, K_VAL, ty, c, 0, ln, cl); m = M_EXPS;
                end else if (c == "f" || c == "F") begin
                    cl = bump(cl); ty = T_FLOAT; m = M_SUFD;
                end else if (c == "d" || c == "D") begin
                    cl = bump(cl); ty = T_DOUBLE; put(bt, K_DONE, ty, 0, 0, ln, cl); m = M_IDLE;
                end else begin
                    put(bt, K_DONE, ty, 0, 0, ln, cl); m = M_IDLE; cons = 0;
                end
            end
            M_SUFD: begin
                if (c == "d" || c == "D") begin cl = bump(cl); ty = T_DOUBLE; end
                else cons = 0;
                put(bt, K_DONE, ty, 0, 0, ln, cl); m = M_IDLE;
            end
            M_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    cl = bump(cl); put(bt, K_VAL, ty, c, 0, ln, cl);
                end else begin
                    put(bt, K_DONE, ty, 0, 0, ln, cl); m = M_IDLE; cons = 0;
                end
            end
            default: begin
                m = M_IDLE;
                cl = bump(cl);
                if (c == 8'h0a) begin
                    ty = T_SYM;
                    put(bt, K_VAL, ty, 8'h5c, 0, ln, cl);
                    put(bt, K_VAL, ty, "n", 0, ln, cl);
                    put(bt, K_DONE, ty, 0, 0, ln, cl);
                    if (ln != PosMax) ln = ln + 1'b1;
                    cl = '0;
                end else if (is_blank(c)) begin
                end else if (c == "/") m = M_SLASH;
                else if (c == 8'h22) begin ty = T_STR; m = M_STR; end
                else if (c == 8'h27) begin ty = T_CHAR; m = M_CHOPEN; end
                else if (is_digit(c)) begin
                    ty = T_INT; put(bt, K_VAL, ty, c, 0, ln, cl);
                    m = (c == "0") ? M_NZERO : M_NINT;
                end else if (is_alpha(c) || c == "_") begin
                    ty = T_IDENT; put(bt, K_VAL, ty, c, 0, ln, cl); m = M_IDENT;
                end else begin
                    ty = T_SYM; put(bt, K_VAL, ty, c, 0, ln, cl);
                    put(bt, K_DONE, ty, 0, 0, ln, cl);
                end
            end
        endcase
        return cons;
    endfunction

    function automatic logic [PosBits-1:0] bump(input logic [PosBits-1:0] x);
        return (x != PosMax) ? x + 1'b1 : x;
    endfunction

    function automatic void put(inout t_batch bt, input logic [1:0] k, input logic [3:0] t,
            input logic [7:0] v, input logic [2:0] e, input logic [PosBits-1:0] ln,
            input logic [PosBits-1:0] cl);
        t_res r;
        r.kind = k; r.ttype = t; r.val = v; r.err = e;
        r.line = ln; r.col = cl; r.any_err = 1'b0;
        if (bt.cnt < 3'(MaxRes)) begin
            bt.res[bt.cnt] = r;
            bt.cnt = bt.cnt + 1'b1;
        end
    endfunction

    // next state and result batch for the current beat
    always_comb begin
        t_mode m;
        logic [PosBits-1:0] ln, cl;
        logic [3:0] ty;
        logic er;
        m = r_mode; ln = r_line; cl = r_col; ty = r_type; er = r_err;
        b = '0;
        n_eof = r_eof;
        if (i_go && !r_eof) begin
            if (i_eos) begin
                case (m)
                    M_SLASH: begin
                        ty = T_SYM; put(b, K_VAL, ty, "/", 0, ln, cl);
                        put(b, K_DONE, ty, 0, 0, ln, cl);
                    end
                    M_BLOCK, M_BSTAR: begin er = 1; put(b, K_ERR, T_EOF, 0, E_BLOCK, ln, cl); end
                    M_STR, M_STRESC: begin
                        er = 1; put(b, K_ERR, T_EOF, 0, E_STREND, ln, cl);
                        put(b, K_DONE, ty, 0, 0, ln, cl);
                    end
                    M_CHOPEN, M_CHESC, M_CHCLOSE: begin
                        er = 1; put(b, K_ERR, T_EOF, 0, E_CHAR, ln, cl);
                        put(b, K_DONE, ty, 0, 0, ln, cl);
                    end
                    M_IDLE, M_LINEC: ;
                    default: put(b, K_DONE, ty, 0, 0, ln, cl);
                endcase
                m = M_IDLE; ty = T_EOF;
                put(b, K_DONE, T_EOF, 0, 0, ln, cl);
                b.res[b.cnt - 1'b1].any_err = er;
                n_eof = 1'b1;
            end else if (!bstep(i_ch, m, ln, cl, ty, er, b)) begin
                void'(bstep(i_ch, m, ln, cl, ty, er, b));
            end
        end
        n_mode = m; n_line = ln; n_col = cl; n_type = ty; n_err = er;
    end

    assign o_batch = b;

    // lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_line <= PosBits'(1); r_col <= '0;
            r_type <= T_EOF; r_err <= 1'b0; r_eof <= 1'b0;
        end else begin
            r_mode <= n_mode; r_line <= n_line; r_col <= n_col;
            r_type <= n_type; r_err <= n_err; r_eof <= n_eof;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_line != '0)
        else $error("line count reached zero");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) $past(r_eof) |-> r_eof)
        else $error("eof flag cleared");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_eof |-> r_mode == M_IDLE)
        else $error("mode active after eof");
endmodule
`default_nettype wire

>>> rtl/stl_outq.sv
// result batch register that drains one result per cycle while i_ready is high
`default_nettype none
module stl_outq import stl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_batch i_batch,
    output logic        o_free,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_res        o_res,
    output logic        o_last
);
    t_batch     r_b;
    logic [2:0] r_idx;
    logic       r_full;
    logic       pop;

    assign o_valid = r_full;
    assign o_res   = r_b.res[r_idx];
    assign o_last  = (r_idx + 1'b1 == r_b.cnt);
    assign pop     = r_full && i_ready;
    assign o_free  = !r_full || (pop && o_last);

    // load on a new batch, step the index per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0; r_idx <= '0;
        end else if (i_load && o_free) begin
            r_full <= i_batch.cnt != '0; r_idx <= '0;
        end else if (pop) begin
            if (o_last) r_full <= 1'b0;
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) r_b <= i_batch;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_full |-> r_idx < r_b.cnt)
        else $error("index past batch");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_b.cnt <= 3'(MaxRes))
        else $error("batch overflow");
endmodule
`default_nettype wire
